[src/sorted_priority_queue_core_defines.svh]
// ---------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property forms, clocked on clk and disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the sorted priority queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int KeyW = 32;
  localparam int CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // compare and shift all cells, write the result
  } spq_cmd_t;

endpackage

[src/spq_ctrl.sv]
// ---------------------------------------------------------------------------
// spq_ctrl
// handshake controller: accepts a beat, runs the execute state, holds result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  // the result register must be free, or freed this cycle, before a new beat
  // no beat is taken while in reset
  assign in_ready = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = (state == S_EXEC) || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign cmd.load = accept;
  assign cmd.exec = (state == S_EXEC);

  `SPQ_ASSERT_IMP(a_exec_out_free, state == S_EXEC, !out_valid, "execute with result pending")
  `SPQ_ASSERT_NXT(a_accept_exec, accept, state == S_EXEC, "accepted beat not executed")
  `SPQ_ASSERT_NXT(a_exec_result, state == S_EXEC, out_valid && state == S_IDLE,
                  "execute did not present a result")

endmodule

[src/spq_dp.sv]
// ---------------------------------------------------------------------------
// spq_dp
// datapath: input register, row of sorted key cells, count, capacity, result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module spq_dp #(
  parameter int  DEPTH = 16,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spq_pkg::spq_cmd_t                 cmd,
  input  logic                              operation,
  input  logic signed [spq_pkg::KeyW-1:0]   value,
  input  logic                              cfg_wen,
  input  logic        [spq_pkg::CapW-1:0]   cfg_wdata,
  output spq_pkg::status_t                  status,
  output logic signed [spq_pkg::KeyW-1:0]   popped_value,
  output logic        [CntW-1:0]            entry_count
);
  import spq_pkg::*;

  localparam int LimW = (CntW > CapW) ? CntW : CapW;

  logic                   op_r;
  logic signed [KeyW-1:0] key_r;
  logic [CapW-1:0]        capacity;
  logic [CntW-1:0]        count;
  logic signed [KeyW-1:0] entries [DEPTH];
  status_t                status_r;
  logic signed [KeyW-1:0] popped_r;

  logic [LimW-1:0] cap_ext;
  logic [LimW-1:0] limit;
  logic            full;
  logic            empty;
  logic            do_ins;
  logic            do_pop;
  logic [DEPTH-1:0] gt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      key_r <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // capacity above the built depth is clamped
  assign cap_ext = LimW'(capacity);
  assign limit   = (cap_ext > LimW'(DEPTH)) ? LimW'(DEPTH) : cap_ext;
  assign full    = (LimW'(count) >= limit);
  assign empty   = (count == '0);
  assign do_ins  = cmd.exec && (op_r == OP_INSERT) && !full;
  assign do_pop  = cmd.exec && (op_r == OP_POP) && !empty;

  // each cell compares in parallel; empty slots count as greater than the key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KeyW-1:0] ins_val;
    logic signed [KeyW-1:0] pop_val;

    assign gt[i] = (CntW'(i) >= count) || (key_r < entries[i]);

    if (i == 0) begin : g_first
      assign ins_val = gt[i] ? key_r : entries[i];
    end else begin : g_rest
      assign ins_val = gt[i] ? (gt[i-1] ? entries[i-1] : key_r) : entries[i];
    end

    if (i < DEPTH - 1) begin : g_shift
      assign pop_val = entries[i+1];
    end else begin : g_top
      assign pop_val = entries[i];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        entries[i] <= ins_val;
      end else if (do_pop) begin
        entries[i] <= pop_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end else if (do_pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_r == OP_INSERT) begin
        status_r <= full ? STAT_FULL : STAT_DONE;
      end else begin
        status_r <= empty ? STAT_EMPTY : STAT_DONE;
      end
      popped_r <= do_pop ? entries[0] : '0;
    end
  end

  assign status       = status_r;
  assign popped_value = popped_r;
  // count only moves in the execute cycle, so it holds while the result waits
  assign entry_count  = count;

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CntW'(DEPTH), "count above depth")
  `SPQ_ASSERT_NXT(a_full_hold, cmd.exec && op_r == OP_INSERT && full, $stable(count),
                  "rejected insert changed count")
  `SPQ_ASSERT_NXT(a_pop_count, do_pop, count == CntW'($past(count) - 1'b1),
                  "pop did not drop count by one")

endmodule

[src/sorted_priority_queue_core.sv]
// ---------------------------------------------------------------------------
// sorted_priority_queue_core
// sorted priority queue of signed 32-bit keys built as a row of shift cells
// ---------------------------------------------------------------------------
// Keys are kept in ascending order in DEPTH cells; an insert lands after all
// equal keys (first-in, first-out among ties) and a pop returns the smallest.
// The accept beat registers each item, and in the next cycle every cell
// compares against the key and shifts in parallel while the result register
// is loaded. A new beat is taken in the cycle the pending result is taken,
// and no new item is taken while one is executing. The capacity register
// resets to 16, is clamped to DEPTH, and should only be written while no
// item is in flight. The key cells have no reset; the count does, so no
// clearing pass is needed after reset.
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
  parameter int  DEPTH = 16,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic signed [spq_pkg::KeyW-1:0] value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic        [1:0]               status,
  output logic signed [spq_pkg::KeyW-1:0] popped_value,
  output logic        [CntW-1:0]          entry_count,
  input  logic                            cfg_wen,
  input  logic        [spq_pkg::CapW-1:0] cfg_wdata
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  status_t  status_w;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .operation    (operation),
    .value        (value),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .status       (status_w),
    .popped_value (popped_value),
    .entry_count  (entry_count)
  );

  assign status = status_w;

endmodule
